/* design/dgb_pkg.sv */
// ----------------------------------------------------------------------------
// dgb_pkg: shared types, constants and functions
// Word types, register indexes, CRC-16/ARC byte update and hex digit encode.
// ----------------------------------------------------------------------------
package dgb_pkg;

  localparam logic [15:0] CrcPoly    = 16'hA001;
  localparam int          JobqDepth  = 4;
  localparam int          JobqAw     = $clog2(JobqDepth);
  localparam int          JobqCw     = $clog2(JobqDepth + 1);
  localparam int          IdChars    = 32;
  localparam int          CharIdxW   = $clog2(IdChars);
  localparam int          CfgIdxW    = 8;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegBusType   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegVendorId  = 8'd1;
  localparam logic [CfgIdxW-1:0] RegProductId = 8'd2;
  localparam logic [CfgIdxW-1:0] RegVersionId = 8'd3;

  // input word functions
  localparam logic FuncAbsorb = 1'b0;
  localparam logic FuncFinish = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] name_byte;
  } dgb_in_t;

  typedef struct packed {
    logic [6:0] hex_char;
    logic       last_char;
  } dgb_out_t;

  typedef struct packed {
    logic [15:0] bus_type;
    logic [15:0] vendor_id;
    logic [15:0] product_id;
    logic [15:0] version_id;
  } dgb_regs_t;

  // queue handshake between front and back
  typedef struct packed {
    logic        push;
    logic        full;
    logic        pop;
    logic        not_empty;
  } dgb_jobq_ctl_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CrcPoly;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic logic [6:0] hex_digit(input logic [3:0] nib);
    logic [6:0] d;
    if (nib < 4'd10) d = 7'h30 + {3'b000, nib};
    else d = 7'h61 + {3'b000, nib} - 7'd10;
    return d;
  endfunction

endpackage

/* design/dgb_front.sv */
// ----------------------------------------------------------------------------
// dgb_front: input side
// Folds name bytes into the running CRC and queues the CRC on a finish word.
// ----------------------------------------------------------------------------
module dgb_front import dgb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dgb_in_t       item,
  input  logic          jobq_full,
  output logic          jobq_push,
  output logic [15:0]   jobq_data
);

  logic [15:0] crc;
  logic [15:0] crc_next;
  logic        accept;

  assign accept    = push && !jobq_full;
  assign jobq_push = accept && (item.func == FuncFinish);
  assign jobq_data = crc;

  always_comb begin
    crc_next = crc;
    if (accept) begin
      if (item.func == FuncFinish) crc_next = 16'h0000;
      else crc_next = crc_byte(crc, item.name_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) crc <= 16'h0000;
    else crc <= crc_next;
  end

endmodule

/* design/dgb_jobq.sv */
// ----------------------------------------------------------------------------
// dgb_jobq: finish job queue
// Short queue of name CRCs between the front and the character sequencer.
// ----------------------------------------------------------------------------
module dgb_jobq import dgb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [15:0]   wdata,
  input  logic          pop,
  output logic [15:0]   rdata,
  output logic          full,
  output logic          not_empty
);

  logic [15:0]       mem [JobqDepth];
  logic [JobqAw-1:0] wr_ptr;
  logic [JobqAw-1:0] rd_ptr;
  logic [JobqCw-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == JobqCw'(JobqDepth));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

/* design/dgb_back.sv */
// ----------------------------------------------------------------------------
// dgb_back: identifier sequencer
// Takes one queued CRC and emits the 32 hex characters through an output register.
// ----------------------------------------------------------------------------
module dgb_back import dgb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  dgb_regs_t     regs,
  input  logic          jobq_not_empty,
  input  logic [15:0]   jobq_data,
  output logic          jobq_pop,
  output logic          empty,
  input  logic          pop,
  output dgb_out_t      result
);

  localparam logic [CharIdxW-1:0] CharLast = CharIdxW'(IdChars - 1);

  logic                busy;
  logic [15:0]         crc;
  logic [CharIdxW-1:0] idx;
  logic                out_valid;
  logic                advance;
  logic [15:0]         word_val;
  logic [7:0]          byte_val;
  logic [3:0]          nib;

  assign empty    = !out_valid;
  assign advance  = !out_valid || pop;
  assign jobq_pop = !busy && jobq_not_empty;

  always_comb begin
    case (idx[4:2])
      3'd0:    word_val = regs.bus_type;
      3'd1:    word_val = crc;
      3'd2:    word_val = regs.vendor_id;
      3'd4:    word_val = regs.product_id;
      3'd6:    word_val = regs.version_id;
      default: word_val = 16'h0000;
    endcase
    // low byte first, high nibble first
    byte_val = idx[1] ? word_val[15:8] : word_val[7:0];
    nib      = idx[0] ? byte_val[3:0] : byte_val[7:4];
  end

  always_ff @(posedge clk) begin
    if (jobq_pop) crc <= jobq_data;
    if (busy && advance) begin
      result.hex_char  <= hex_digit(nib);
      result.last_char <= (idx == CharLast);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (jobq_pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy && advance) begin
        idx <= idx + 1'b1;
        if (idx == CharLast) busy <= 1'b0;
      end
      if (busy && advance) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

endmodule

/* design/device_guid_builder_crc16_core.sv */
// ----------------------------------------------------------------------------
// device_guid_builder_crc16_core: device identifier builder
// Name bytes feed a CRC-16/ARC; a finish word emits the 32-char hex identifier.
// ----------------------------------------------------------------------------
// Path: a name byte is folded into the CRC register; the first character of a finish
// passes through the job queue, the sequencer load and the output register.
// Throughput: 1 input word per cycle while the job queue is not full; the sequencer
// emits one character per cycle unless pop stalls it, and loads a CRC once idle.
// Reset: rst clears the CRC, empties the job queue, idles the sequencer and clears the registers to 0.
module device_guid_builder_crc16_core import dgb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  dgb_in_t            item,
  output logic               empty,
  input  logic               pop,
  output dgb_out_t           result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [15:0]        cfg_data
);

  dgb_regs_t     regs;
  dgb_jobq_ctl_t q;
  logic [15:0]   q_wdata;
  logic [15:0]   q_rdata;

  assign cfg_ready = 1'b1;
  assign full      = q.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegBusType:   regs.bus_type   <= cfg_data;
        RegVendorId:  regs.vendor_id  <= cfg_data;
        RegProductId: regs.product_id <= cfg_data;
        RegVersionId: regs.version_id <= cfg_data;
        default: ;
      endcase
    end
  end

  dgb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .jobq_full (q.full),
    .jobq_push (q.push),
    .jobq_data (q_wdata)
  );

  dgb_jobq u_jobq (
    .clk       (clk),
    .rst       (rst),
    .push      (q.push),
    .wdata     (q_wdata),
    .pop       (q.pop),
    .rdata     (q_rdata),
    .full      (q.full),
    .not_empty (q.not_empty)
  );

  dgb_back u_back (
    .clk            (clk),
    .rst            (rst),
    .regs           (regs),
    .jobq_not_empty (q.not_empty),
    .jobq_data      (q_rdata),
    .jobq_pop       (q.pop),
    .empty          (empty),
    .pop            (pop),
    .result         (result)
  );

endmodule

/* design/dgb_checker.sv */
// ----------------------------------------------------------------------------
// dgb_checker: port-level checks
// Watches the result queue side of the identifier builder.
// ----------------------------------------------------------------------------
module dgb_checker import dgb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     empty,
  input  logic     pop,
  input  dgb_out_t result
);

  // no word survives reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("stalled result word changed");

  // every character is a lowercase hex digit
  a_hex: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((result.hex_char >= 7'h30 && result.hex_char <= 7'h39) ||
                (result.hex_char >= 7'h61 && result.hex_char <= 7'h66)))
    else $error("result is not a hex digit");

  // a new identifier cannot end right after the previous one
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && result.last_char) |=> !(!empty && result.last_char))
    else $error("back to back final characters");

endmodule

bind device_guid_builder_crc16_core dgb_checker u_dgb_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
